// File: design/text_mode_glyph_renderer_top_assert.svh
// Assertion macros used by the top-level design file.
// Each macro samples on clk and is disabled while rst is high.
`ifndef TEXT_MODE_GLYPH_RENDERER_TOP_ASSERT_SVH
`define TEXT_MODE_GLYPH_RENDERER_TOP_ASSERT_SVH

// Condition in the current cycle implies consequence in the same cycle.
`define TMGR_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Condition in the current cycle implies consequence in the next cycle.
`define TMGR_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/tmgr_pkg.sv
package tmgr_pkg;

  localparam int OP_W       = 2;
  localparam int COLUMN_W   = 7;
  localparam int LINE_W     = 5;
  localparam int CODE_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int GLINE_W    = 4;
  localparam int GBITS_W    = 8;
  localparam int PIXEL_W    = 4;
  localparam int ROW_PIXELS = 8;
  localparam int ROW_W      = PIXEL_W * ROW_PIXELS;
  localparam int CELL_W     = ATTR_W + CODE_W;
  localparam int BLINK_W    = 11;
  localparam int CHARS      = 256;

  localparam logic [OP_W-1:0] OP_WRITE_CELL  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_GLYPH = 2'd1;
  localparam logic [OP_W-1:0] OP_RENDER      = 2'd2;

  typedef logic [BLINK_W-1:0] blink_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [COLUMN_W-1:0] column;
    logic [LINE_W-1:0]   line;
    logic [CODE_W-1:0]   char_code;
    logic [ATTR_W-1:0]   attribute;
    logic [GLINE_W-1:0]  glyph_line;
    logic [GBITS_W-1:0]  glyph_bits;
    logic                blink_phase;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] pixel_row;
    logic             any_blinking;
  } out_item_t;

endpackage

// File: design/tmgr_paint.sv
module tmgr_paint (
  input  logic [tmgr_pkg::ATTR_W-1:0]  attr,
  input  logic [tmgr_pkg::GBITS_W-1:0] bits,
  input  logic                         phase,
  output logic [tmgr_pkg::ROW_W-1:0]   pixel_row
);

  logic [tmgr_pkg::PIXEL_W-1:0] fg;
  logic [tmgr_pkg::PIXEL_W-1:0] bg;

  // Background bit 3 marks a blinking cell: drop it, and hide fg in phase 0.
  always_comb begin
    fg = attr[3:0];
    bg = attr[7:4];
    if (bg[3]) begin
      bg[3] = 1'b0;
      if (!phase) begin
        fg = bg;
      end
    end
  end

  // Font MSB is the leftmost pixel, which lands in the low nibble.
  for (genvar i = 0; i < tmgr_pkg::ROW_PIXELS; i++) begin : g_pix
    assign pixel_row[tmgr_pkg::PIXEL_W*i +: tmgr_pkg::PIXEL_W] =
      bits[tmgr_pkg::ROW_PIXELS-1-i] ? fg : bg;
  end

endmodule

// File: design/text_mode_glyph_renderer_top.sv
// Text-mode character generator. Each item either writes a cell (character
// and attribute), writes one font row of the glyph store, or renders one
// font row of a stored cell as eight 4-bit colour indices, leftmost pixel in
// the low nibble; the unused op code changes nothing. Every item returns
// exactly one result item, which also flags whether any stored cell has its
// blink bit set. Cell and glyph state live in two single-port synchronous
// memories. One item is in flight at a time: a cell or glyph write passes
// through S_IDLE and S_CELL (cell read, then the cell or glyph row write),
// a render through S_IDLE, S_CELL and S_GLYPH (cell read, then the
// dependent glyph read), and each waits in its last state on result_ready.
// After reset the block sweeps the cell store to zero, one entry a cycle,
// so item_ready stays low until every entry has been cleared. Glyph rows
// must be written before they are rendered. Out-of-screen cell writes and
// out-of-glyph row writes are dropped; renders of such cells or rows show
// background colour 0 or the all-background row.
module text_mode_glyph_renderer_top #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tmgr_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output tmgr_pkg::out_item_t  result
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int GLYPH_ROWS = tmgr_pkg::CHARS * GLYPH_HEIGHT;
  localparam int GLYPH_AW   = $clog2(GLYPH_ROWS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CELL  = 2'd2;
  localparam logic [1:0] S_GLYPH = 2'd3;

  // Memories.
  logic [tmgr_pkg::CELL_W-1:0]  cell_mem [CELL_COUNT];
  logic [tmgr_pkg::GBITS_W-1:0] glyph_mem [GLYPH_ROWS];

  logic [tmgr_pkg::CELL_W-1:0]  cell_q;
  logic [tmgr_pkg::GBITS_W-1:0] glyph_q;

  // Control and held item.
  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [CELL_AW-1:0]    clear_addr;
  tmgr_pkg::in_item_t    req;
  logic [CELL_AW-1:0]    cell_addr;
  logic                  cell_ok;
  tmgr_pkg::blink_t      blink_count;
  tmgr_pkg::blink_t      blink_count_next;
  tmgr_pkg::out_item_t   result_next;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  cell_we;
  logic [CELL_AW-1:0]    cell_waddr;
  logic [tmgr_pkg::CELL_W-1:0] cell_wdata;
  logic                  glyph_we;
  logic                  glyph_re;
  logic [GLYPH_AW-1:0]   glyph_waddr;
  logic [GLYPH_AW-1:0]   glyph_raddr;
  logic                  gline_ok;
  logic [tmgr_pkg::CELL_W-1:0]  cell_val;
  logic [tmgr_pkg::GBITS_W-1:0] font_bits;
  logic [tmgr_pkg::ROW_W-1:0]   painted;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // Retire the held item once the result register can take it.
  assign finish = out_free && ((state == S_GLYPH) ||
                               ((state == S_CELL) && (req.op != tmgr_pkg::OP_RENDER)));

  assign gline_ok = 32'(req.glyph_line) < GLYPH_HEIGHT;

  // Off-screen cells render as character 0, attribute 0.
  assign cell_val  = cell_ok ? cell_q : '0;
  assign font_bits = gline_ok ? glyph_q : '0;

  // Cell store port: clearing sweep, else write back of a cell write.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_addr;
    cell_wdata = {req.attribute, req.char_code};
    if (state == S_CLEAR) begin
      cell_we    = 1'b1;
      cell_waddr = clear_addr;
      cell_wdata = '0;
    end else if (finish && (state == S_CELL) &&
                 (req.op == tmgr_pkg::OP_WRITE_CELL) && cell_ok) begin
      cell_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (accept) begin
      cell_q <= cell_mem[CELL_AW'(32'(item.line) * COLUMNS + 32'(item.column))];
    end
  end

  // Glyph store port.
  assign glyph_we    = finish && (state == S_CELL) &&
                       (req.op == tmgr_pkg::OP_WRITE_GLYPH) && gline_ok;
  assign glyph_waddr = GLYPH_AW'(32'(req.char_code) * GLYPH_HEIGHT + 32'(req.glyph_line));
  assign glyph_re    = (state == S_CELL) && (req.op == tmgr_pkg::OP_RENDER);
  assign glyph_raddr = GLYPH_AW'(32'(cell_val[tmgr_pkg::CODE_W-1:0]) * GLYPH_HEIGHT +
                                 32'(req.glyph_line));

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_waddr] <= req.glyph_bits;
    end
    if (glyph_re) begin
      glyph_q <= glyph_mem[glyph_raddr];
    end
  end

  tmgr_paint u_paint (
    .attr      (cell_val[tmgr_pkg::CELL_W-1:tmgr_pkg::CODE_W]),
    .bits      (font_bits),
    .phase     (req.blink_phase),
    .pixel_row (painted)
  );

  // Blink count: drop the old cell's blink bit, add the new one.
  always_comb begin
    blink_count_next = blink_count;
    if (cell_we && (state == S_CELL)) begin
      blink_count_next = blink_count - tmgr_pkg::blink_t'(cell_q[tmgr_pkg::CELL_W-1])
                         + tmgr_pkg::blink_t'(req.attribute[tmgr_pkg::ATTR_W-1]);
    end
  end

  always_comb begin
    result_next.pixel_row    = (state == S_GLYPH) ? painted : '0;
    result_next.any_blinking = (blink_count_next != '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clear_addr == CELL_AW'(CELL_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        if (req.op == tmgr_pkg::OP_RENDER) begin
          state_next = S_GLYPH;
        end else if (finish) begin
          state_next = S_IDLE;
        end
      end
      S_GLYPH: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_addr   <= '0;
      blink_count  <= '0;
      result_valid <= 1'b0;
    end else begin
      state       <= state_next;
      blink_count <= blink_count_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + CELL_AW'(1);
      end
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted item and its decoded cell address; register the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= item;
      cell_addr <= CELL_AW'(32'(item.line) * COLUMNS + 32'(item.column));
      cell_ok   <= (32'(item.column) < COLUMNS) && (32'(item.line) < ROWS);
    end
    if (finish) begin
      result <= result_next;
    end
  end

`include "text_mode_glyph_renderer_top_assert.svh"

  `TMGR_ASSERT_NEXT(a_clear_done, (state == S_CLEAR) && (clear_addr == CELL_AW'(CELL_COUNT - 1)), state == S_IDLE)
  `TMGR_ASSERT_NEXT(a_accept_reads_cell, accept, state == S_CELL)
  `TMGR_ASSERT_NEXT(a_write_result_zero, finish && (state == S_CELL), result_valid && (result.pixel_row == '0))
  `TMGR_ASSERT_NEXT(a_blink_step, state != S_CLEAR, (blink_count == $past(blink_count)) || (blink_count == $past(blink_count) + tmgr_pkg::blink_t'(1)) || (blink_count == $past(blink_count) - tmgr_pkg::blink_t'(1)))

endmodule

// File: tb/text_mode_glyph_renderer_top_tb.sv
`timescale 1ns / 1ps

module text_mode_glyph_renderer_top_tb;
  import tmgr_pkg::*;

  // Screen and font geometry; must match the parameters passed to dut.
  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int GLYPH_HEIGHT = 16;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int GLYPH_ROWS   = CHARS * GLYPH_HEIGHT;

  // The block ignores this op code; the package only names the live ones.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Random items after the directed ones. Every item returns exactly one
  // result item, so the directed and random items together come to 800, as do the results.
  localparam int RANDOM_ITEMS = 776;
  // Items and results with no idling on either side.
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 450;
  // After this many results, hold result_ready low once; HOLD_CYCLES sets how long.
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 200;
  // Idle chance per cycle, in percent, outside the quiet window.
  localparam int IDLE_PCT     = 11;
  // Drain time after the last expected result, and the hard stop. The
  // hard stop covers the reset sweep, every item with its sender gaps and
  // receiver stalls, and one long hold.
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  in_item_t    item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;

  text_mode_glyph_renderer_top #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset at the start, then release it for good.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Screen model: mirrors of the cell store and the font, a mask of font
  // rows that have been loaded, and the running count of blinking cells.
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0]  cell_mirror [CELL_COUNT] = '{default: '0};
  logic [GBITS_W-1:0] font_mirror [GLYPH_ROWS] = '{default: '0};
  bit                 font_loaded [GLYPH_ROWS] = '{default: 1'b0};
  blink_t             blink_total = '0;

  // Expected result items, oldest first.
  out_item_t pending_rows [$];

  // Directed stimulus: the item, and where it is obvious, its result.
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } vector_t;

  vector_t stim_table [$];

  int fail_count = 0;
  bit stim_done  = 1'b0;

  // Apply one accepted item to the screen model and return its result.
  function automatic out_item_t predict_pixels(in_item_t it);
    out_item_t           res;
    logic [CELL_W-1:0]   word;
    logic [GBITS_W-1:0]  bits;
    logic [PIXEL_W-1:0]  fg;
    logic [PIXEL_W-1:0]  bg;
    bit                  on_screen;
    int                  idx;
    res       = '0;
    on_screen = (it.column < COLUMNS) && (it.line < ROWS);
    idx       = it.line * COLUMNS + it.column;
    case (it.op)
      OP_WRITE_CELL: begin
        // Off-screen cell writes are dropped; otherwise swap the blink bit and store the cell.
        if (on_screen) begin
          blink_total = blink_total - blink_t'(cell_mirror[idx][CELL_W-1])
                        + blink_t'(it.attribute[ATTR_W-1]);
          cell_mirror[idx] = {it.attribute, it.char_code};
        end
      end
      OP_WRITE_GLYPH: begin
        if (it.glyph_line < GLYPH_HEIGHT) begin
          font_mirror[it.char_code * GLYPH_HEIGHT + it.glyph_line] = it.glyph_bits;
          font_loaded[it.char_code * GLYPH_HEIGHT + it.glyph_line] = 1'b1;
        end
      end
      OP_RENDER: begin
        // Off-screen cells read as character 0 with attribute 0.
        word = on_screen ? cell_mirror[idx] : '0;
        bits = (it.glyph_line < GLYPH_HEIGHT) ?
               font_mirror[word[CODE_W-1:0] * GLYPH_HEIGHT + it.glyph_line] : '0;
        fg = word[CODE_W +: PIXEL_W];
        bg = word[CODE_W + PIXEL_W +: PIXEL_W];
        // Blink: clear the top background bit, hide the foreground in phase 0.
        if (bg[PIXEL_W-1]) begin
          bg[PIXEL_W-1] = 1'b0;
          if (!it.blink_phase) fg = bg;
        end
        // Leftmost pixel comes from the font MSB and lands in the low nibble.
        for (int i = 0; i < ROW_PIXELS; i++) begin
          res.pixel_row[PIXEL_W*i +: PIXEL_W] = bits[GBITS_W-1-i] ? fg : bg;
        end
      end
      default: ;
    endcase
    res.any_blinking = (blink_total != '0);
    return res;
  endfunction

  function automatic void add_vector(logic [OP_W-1:0] op, int column, int line,
                                     int code, int attr, int gline, int gbits,
                                     bit phase, bit typed, logic [ROW_W-1:0] row,
                                     bit blink);
    vector_t v;
    v.stim.op          = op;
    v.stim.column      = column[COLUMN_W-1:0];
    v.stim.line        = line[LINE_W-1:0];
    v.stim.char_code   = code[CODE_W-1:0];
    v.stim.attribute   = attr[ATTR_W-1:0];
    v.stim.glyph_line  = gline[GLINE_W-1:0];
    v.stim.glyph_bits  = gbits[GBITS_W-1:0];
    v.stim.blink_phase = phase;
    v.typed            = typed;
    v.want.pixel_row    = row;
    v.want.any_blinking = blink;
    stim_table.push_back(v);
  endfunction

  task automatic report_mismatch(string what, logic [ROW_W-1:0] got,
                                 logic [ROW_W-1:0] want);
    fail_count++;
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Sender: walk the directed table, then random items. Each accepted
  // item goes through the screen model at the edge that accepts it, and
  // the next item is built from the model state right after.
  // ---------------------------------------------------------------------
  initial begin : feed
    in_item_t  nxt;
    out_item_t got;
    out_item_t typed_want;
    bit        typed_now;
    bit        accepted;
    bit        quiet;
    bit        near;
    bit        on_screen;
    int        issued;
    int        total;
    int        roll;
    int        ch;
    typed_now  = 1'b0;
    typed_want = '0;
    issued     = 0;

    // Load one font row of character 0 so renders of empty or off-screen
    // cells have a defined glyph row to read.
    add_vector(OP_WRITE_GLYPH, 0, 0, 8'h00, 8'h00, 0, 8'hA5, 1'b0, 1, '0, 1'b0);
    add_vector(OP_RENDER, 0, 0, 0, 0, 0, 0, 1'b1, 1, '0, 1'b0);
    // Plain cell: fg E, bg 1, no blink.
    add_vector(OP_WRITE_CELL, 0, 0, 8'h41, 8'h1E, 0, 0, 1'b0, 1, '0, 1'b0);
    add_vector(OP_WRITE_GLYPH, 0, 0, 8'h41, 0, 3, 8'h81, 1'b0, 1, '0, 1'b0);
    add_vector(OP_RENDER, 0, 0, 0, 0, 3, 0, 1'b0, 0, '0, 1'b0);
    // Blinking cell in both phases.
    add_vector(OP_WRITE_CELL, 1, 0, 8'h41, 8'h9C, 0, 0, 1'b0, 1, '0, 1'b1);
    add_vector(OP_RENDER, 1, 0, 0, 0, 3, 0, 1'b0, 0, '0, 1'b0);
    add_vector(OP_RENDER, 1, 0, 0, 0, 3, 0, 1'b1, 0, '0, 1'b0);
    // Last cell on screen, top character, last scan line.
    add_vector(OP_WRITE_CELL, COLUMNS-1, ROWS-1, 8'hFF, 8'hF0, 0, 0, 1'b0, 1, '0, 1'b1);
    add_vector(OP_WRITE_GLYPH, 0, 0, 8'hFF, 0, 15, 8'hFF, 1'b0, 1, '0, 1'b1);
    add_vector(OP_RENDER, COLUMNS-1, ROWS-1, 0, 0, 15, 0, 1'b0, 0, '0, 1'b0);
    add_vector(OP_RENDER, COLUMNS-1, ROWS-1, 0, 0, 15, 0, 1'b1, 0, '0, 1'b0);
    add_vector(OP_WRITE_GLYPH, 0, 0, 8'hFF, 0, 15, 8'h00, 1'b0, 1, '0, 1'b1);
    add_vector(OP_RENDER, COLUMNS-1, ROWS-1, 0, 0, 15, 0, 1'b1, 0, '0, 1'b0);
    // Off-screen cell writes are dropped; off-screen renders are all zero.
    add_vector(OP_WRITE_CELL, COLUMNS, 0, 8'h00, 8'h80, 0, 0, 1'b0, 1, '0, 1'b1);
    add_vector(OP_WRITE_CELL, 127, 31, 8'hFF, 8'hFF, 15, 8'hFF, 1'b1, 1, '0, 1'b1);
    add_vector(OP_RENDER, 127, 31, 8'hFF, 8'hFF, 0, 8'hFF, 1'b1, 1, '0, 1'b1);
    add_vector(OP_RENDER, 0, ROWS, 0, 0, 0, 0, 1'b0, 1, '0, 1'b1);
    // Unused op changes nothing.
    add_vector(OP_UNUSED, 127, 31, 8'hFF, 8'hFF, 15, 8'hFF, 1'b1, 1, '0, 1'b1);
    add_vector(OP_UNUSED, 0, 0, 0, 0, 0, 0, 1'b0, 1, '0, 1'b1);
    // Overwrites: blink to blink keeps the count, then drop both blinkers.
    add_vector(OP_WRITE_CELL, 1, 0, 8'h41, 8'h80, 0, 0, 1'b0, 1, '0, 1'b1);
    add_vector(OP_WRITE_CELL, 1, 0, 8'h00, 8'h00, 0, 0, 1'b0, 1, '0, 1'b1);
    add_vector(OP_WRITE_CELL, COLUMNS-1, ROWS-1, 8'h00, 8'h7F, 0, 0, 1'b0, 1, '0, 1'b0);
    add_vector(OP_RENDER, COLUMNS-1, ROWS-1, 0, 0, 0, 0, 1'b0, 0, '0, 1'b0);

    total = stim_table.size() + RANDOM_ITEMS;

    while (rst) @(posedge clk);

    while (!stim_done) begin
      @(posedge clk);
      accepted = item_valid && item_ready;
      if (accepted) begin
        got = predict_pixels(item);
        pending_rows.push_back(typed_now ? typed_want : got);
        issued++;
      end
      // Hold the offered item until it is taken.
      if (item_valid && !accepted) continue;

      quiet = (issued >= QUIET_FROM) && (issued < QUIET_TO);
      if (issued >= total) begin
        item_valid <= 1'b0;
        stim_done = 1'b1;
      end else if (!quiet && $urandom_range(99) < IDLE_PCT) begin
        item_valid <= 1'b0;
      end else begin
        if (issued < stim_table.size()) begin
          nxt        = stim_table[issued].stim;
          typed_now  = stim_table[issued].typed;
          typed_want = stim_table[issued].want;
        end else begin
          typed_now = 1'b0;
          // Fill every field at random, then steer the op and address.
          nxt.char_code   = $urandom_range(255);
          nxt.attribute   = $urandom_range(255);
          nxt.glyph_line  = $urandom_range(15);
          nxt.glyph_bits  = $urandom_range(255);
          nxt.blink_phase = $urandom_range(1);
          // Crowd writes and renders into a small corner so cells get
          // overwritten and read back often.
          near = ($urandom_range(99) < 40);
          if ($urandom_range(99) < 6)
            nxt.column = $urandom_range(127, COLUMNS);
          else
            nxt.column = near ? $urandom_range(7) : $urandom_range(COLUMNS-1);
          if ($urandom_range(99) < 6)
            nxt.line = $urandom_range(31, ROWS);
          else
            nxt.line = near ? $urandom_range(3) : $urandom_range(ROWS-1);

          roll = $urandom_range(99);
          if (roll < 30) begin
            nxt.op = OP_WRITE_CELL;
            if ($urandom_range(1)) nxt.char_code = $urandom_range(7);
          end else if (roll < 50) begin
            nxt.op = OP_WRITE_GLYPH;
            if ($urandom_range(1)) nxt.char_code = $urandom_range(7);
          end else if (roll < 95) begin
            nxt.op = OP_RENDER;
            // Never render a font row that was not loaded: load it instead.
            on_screen = (nxt.column < COLUMNS) && (nxt.line < ROWS);
            ch = on_screen ? cell_mirror[nxt.line * COLUMNS + nxt.column][CODE_W-1:0] : 0;
            if (!font_loaded[ch * GLYPH_HEIGHT + nxt.glyph_line]) begin
              nxt.op        = OP_WRITE_GLYPH;
              nxt.char_code = ch[CODE_W-1:0];
            end
          end else begin
            nxt.op = OP_UNUSED;
          end
        end
        item       <= nxt;
        item_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: check each result against the oldest expectation, stall at
  // random, and once hold off long enough for the block to back up.
  // ---------------------------------------------------------------------
  initial begin : drain
    out_item_t want;
    int        seen;
    int        hold_left;
    bit        held;
    bit        quiet;
    seen      = 0;
    hold_left = 0;
    held      = 1'b0;

    while (rst) @(posedge clk);

    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("result with nothing pending", result.pixel_row, '0);
        end else begin
          want = pending_rows.pop_front();
          if (result.pixel_row !== want.pixel_row)
            report_mismatch("pixel_row", result.pixel_row, want.pixel_row);
          if (result.any_blinking !== want.any_blinking)
            report_mismatch("any_blinking", result.any_blinking, want.any_blinking);
        end
        seen++;
      end

      quiet = (seen >= QUIET_FROM) && (seen < QUIET_TO);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (seen >= HOLD_AT && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Wait for the last result, let the block settle, then report.
  initial begin : finish_run
    wait (stim_done);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: text_mode_glyph_renderer_top.f
+incdir+design
design/tmgr_pkg.sv
design/tmgr_paint.sv
design/text_mode_glyph_renderer_top.sv
tb/text_mode_glyph_renderer_top_tb.sv
